// ===== hw/rtl/ppsc_pkg.sv =====
package ppsc_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned LookaheadWidth = 31;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_LOOKAHEAD_DIST = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DESIRED_LINEAR_VEL = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_ANGULAR_VEL = 2'd2;

   localparam logic [LookaheadWidth-1:0] LOOKAHEAD_RESET = 31'd26214;
   localparam logic signed [CoordWidth-1:0] LINEAR_VEL_RESET = 32'sd13107;
   localparam logic signed [CoordWidth-1:0] ANGULAR_VEL_RESET = 32'sd65536;

   typedef struct packed {
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic is_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] linear_cmd;
      logic signed [CoordWidth-1:0] angular_cmd;
      logic target_beyond_lookahead;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/ppsc_stream_if.sv =====
interface ppsc_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/pure_pursuit_steering_core.sv =====
// Pure pursuit steering core.
// Path points enter on req_chan, one per transfer, already in the robot frame.
// The first point whose distance reaches the lookahead distance becomes the
// target; if none does, the point flagged is_last is used. Each is_last point
// produces one command transfer on rsp_chan; other points produce nothing.
// The csr_ port writes the three settings; the user must use it only while
// idle, as the core does not enforce this. A non-last point arriving after a
// target is latched is dropped. Any other non-last point makes three passes
// through the single 32x32 multiplier (x squared, y squared, lookahead
// squared), the last with the compare. A last point makes the same passes
// unless a target is latched, then a product pass for speed times lateral
// offset, a restoring divider that retires one quotient bit per cycle, and
// the output load. A target at x <= 0 (not ahead) skips product and divider.
// req_chan.ready is high only while the sequencer is idle. A finished command
// sits in the output register until taken; if the receiver stalls, the next
// result waits in the sequencer, while new points are still accepted after
// the previous command has been loaded. Reset restores the default settings,
// drops any latched target and empties the output register.
module pure_pursuit_steering_core (
   input logic clock,
   input logic reset,
   ppsc_stream_if.sink req_chan,
   ppsc_stream_if.source rsp_chan,
   input logic csr_write_en,
   input logic [ppsc_pkg::CsrIndexWidth-1:0] csr_index,
   input logic [ppsc_pkg::CsrDataWidth-1:0] csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MX = 3'd1;
   localparam logic [2:0] S_MY = 3'd2;
   localparam logic [2:0] S_ML = 3'd3;
   localparam logic [2:0] S_CHK = 3'd4;
   localparam logic [2:0] S_MP = 3'd5;
   localparam logic [2:0] S_DIV = 3'd6;
   localparam logic [2:0] S_OUT = 3'd7;

   localparam logic [5:0] DivLastStep = 6'd32;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   logic [2:0] state_ff, state_in;
   logic [30:0] lookahead_ff, lookahead_in;
   logic [31:0] lin_vel_ff, lin_vel_in;
   logic [31:0] max_ang_ff, max_ang_in;
   logic [31:0] px_ff, px_in, py_ff, py_in;
   logic last_ff, last_in;
   logic found_ff, found_in;
   logic beyond_ff, beyond_in;
   logic [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [62:0] td_ff, td_in;
   logic [63:0] acc_ff, acc_in;
   logic [62:0] rem_ff, rem_in;
   logic [32:0] low_ff, low_in;
   logic [32:0] quo_ff, quo_in;
   logic ovf_ff, ovf_in;
   logic direct_ff, direct_in;
   logic [5:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   ppsc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic accept, hit, load;
   logic [63:0] div_shift;
   logic div_fit;
   logic [31:0] mag_max, q_clamped;
   logic neg;

   assign mul_p = 64'(mul_a) * 64'(mul_b);
   assign accept = req_chan.valid && req_chan.ready;
   assign hit = acc_ff >= mul_p;
   assign div_shift = {rem_ff, low_ff[32]};
   assign div_fit = div_shift >= {1'b0, td_ff};
   assign mag_max = mag32(max_ang_ff);
   assign neg = lin_vel_ff[31] ^ ty_ff[31];
   assign load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // The clamp bound never exceeds 2^31, so a clamped quotient fits 32 bits.
   assign q_clamped = (ovf_ff || (quo_ff > {1'b0, mag_max})) ? mag_max : quo_ff[31:0];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      unique case (state_ff)
         S_MX: begin
            mul_a = mag32(px_ff);
            mul_b = mag32(px_ff);
         end
         S_MY: begin
            mul_a = mag32(py_ff);
            mul_b = mag32(py_ff);
         end
         S_ML: begin
            mul_a = {1'b0, lookahead_ff};
            mul_b = {1'b0, lookahead_ff};
         end
         S_MP: begin
            mul_a = mag32(lin_vel_ff);
            mul_b = mag32(ty_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      lookahead_in = lookahead_ff;
      lin_vel_in = lin_vel_ff;
      max_ang_in = max_ang_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ppsc_pkg::CSR_LOOKAHEAD_DIST: lookahead_in = csr_wdata[30:0];
            ppsc_pkg::CSR_DESIRED_LINEAR_VEL: lin_vel_in = csr_wdata;
            ppsc_pkg::CSR_MAX_ANGULAR_VEL: max_ang_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      px_in = px_ff;
      py_in = py_ff;
      last_in = last_ff;
      found_in = found_ff;
      beyond_in = beyond_ff;
      tx_in = tx_ff;
      ty_in = ty_ff;
      td_in = td_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      direct_in = direct_ff;
      cnt_in = cnt_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               px_in = req_chan.payload.point_x;
               py_in = req_chan.payload.point_y;
               last_in = req_chan.payload.is_last;
               if (!found_ff) begin
                  state_in = S_MX;
               end else if (req_chan.payload.is_last) begin
                  beyond_in = 1'b1;
                  state_in = S_CHK;
               end
            end
         end
         S_MX: begin
            acc_in = mul_p;
            state_in = S_MY;
         end
         S_MY: begin
            acc_in = acc_ff + mul_p;
            state_in = S_ML;
         end
         S_ML: begin
            // On a last point with no target yet, the point itself is used.
            // The divisor only matters for x > 0, where it stays below 2^63.
            if (hit || last_ff) begin
               tx_in = px_ff;
               ty_in = py_ff;
               td_in = acc_ff[62:0];
            end
            if (last_ff) begin
               beyond_in = hit;
               state_in = S_CHK;
            end else begin
               found_in = hit;
               state_in = S_IDLE;
            end
         end
         S_CHK: begin
            found_in = 1'b0;
            if (tx_ff[31] || (tx_ff == '0)) begin
               direct_in = 1'b1;
               state_in = S_OUT;
            end else begin
               direct_in = 1'b0;
               state_in = S_MP;
            end
         end
         S_MP: begin
            // The dividend is the product shifted up by 17 bits. Its part above
            // the 33 quotient bits must stay below the divisor, else the
            // quotient is far above any clamp bound.
            rem_in = {16'd0, mul_p[62:16]};
            ovf_in = {16'd0, mul_p[62:16]} >= td_ff;
            low_in = {mul_p[15:0], 17'd0};
            quo_in = '0;
            cnt_in = '0;
            state_in = ({16'd0, mul_p[62:16]} >= td_ff) ? S_OUT : S_DIV;
         end
         S_DIV: begin
            rem_in = div_fit ? (div_shift[62:0] - td_ff) : div_shift[62:0];
            quo_in = {quo_ff[31:0], div_fit};
            low_in = {low_ff[31:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DivLastStep) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.target_beyond_lookahead = beyond_ff;
               if (direct_ff) begin
                  rsp_data_in.linear_cmd = '0;
                  rsp_data_in.angular_cmd = max_ang_ff;
               end else begin
                  rsp_data_in.linear_cmd = lin_vel_ff;
                  if (neg) begin
                     rsp_data_in.angular_cmd = ~q_clamped + 32'd1;
                  end else if (q_clamped[31]) begin
                     rsp_data_in.angular_cmd = 32'h7FFF_FFFF;
                  end else begin
                     rsp_data_in.angular_cmd = q_clamped;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lookahead_ff <= ppsc_pkg::LOOKAHEAD_RESET;
         lin_vel_ff <= ppsc_pkg::LINEAR_VEL_RESET;
         max_ang_ff <= ppsc_pkg::ANGULAR_VEL_RESET;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         lookahead_ff <= lookahead_in;
         lin_vel_ff <= lin_vel_in;
         max_ang_ff <= max_ang_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      last_ff <= last_in;
      beyond_ff <= beyond_in;
      tx_ff <= tx_in;
      ty_ff <= ty_in;
      td_ff <= td_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      direct_ff <= direct_in;
      cnt_ff <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hw/rtl/ppsc_checker.sv =====
module ppsc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_is_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input ppsc_pkg::rsp_payload_type rsp_payload
);

   // A stalled command must hold its value until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // A point that is not last never causes a new command.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_is_last |=> !$rose(rsp_valid))
      else $error("command appeared after a non-last point");

   // A last point always starts computation, so no new point is taken next.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("input still ready after a last point");

   // A command is loaded only while the sequencer is busy.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("command loaded while idle");

   // Reset empties the output register.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind pure_pursuit_steering_core ppsc_checker u_ppsc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_is_last(req_chan.payload.is_last),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_payload(rsp_chan.payload)
);
